// File: rtl/core/pfe_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions of the pheromone field engine
// no dependencies

package pfe_pkg;

  localparam int MAX_DOMAINS = 16;
  localparam int LVL_W       = 16;
  localparam int WGT_DEFAULT = 52428;
  localparam int LOSS_MAX    = 1048575;
  localparam int LOSS_MIN    = -1048576;
  localparam int GAIN_MAX    = 1048575;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_DEP   = 3'd1,
    REQ_SET   = 3'd2,
    REQ_READ  = 3'd3,
    REQ_WGT   = 3'd4,
    REQ_CLEAR = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    CFG_COUNT = 3'd0,
    CFG_EVAP  = 3'd1,
    CFG_DIFF  = 3'd2,
    CFG_DLIM  = 3'd3,
    CFG_FLOOR = 3'd4,
    CFG_CEIL  = 3'd5,
    CFG_DON   = 3'd6
  } cfg_idx_e;

  localparam logic [15:0] LVL_INIT [16] = '{
    16'd8192, 16'd8955, 16'd8745, 16'd7829, 16'd7375, 16'd7963, 16'd8842, 16'd8892,
    16'd8049, 16'd7388, 16'd7752, 16'd8677, 16'd8983, 16'd8280, 16'd7464, 16'd7576
  };

  function automatic logic signed [15:0] lvl_init(input int d);
    logic [3:0] k;
    k = d[3:0];
    if (d < 16) return $signed(LVL_INIT[k]);
    return 16'sd8192;
  endfunction

  // star from domain 0 plus ring 1..5, symmetric
  function automatic logic [15:0] wgt_init(input int r, input int c, input int maxd);
    logic star;
    logic ring;
    star = (r == 0 && c >= 1 && c <= 5) || (c == 0 && r >= 1 && r <= 5);
    ring = (r >= 1 && r <= 5 && c >= 1 && c <= 5) &&
           ((r - c == 1) || (c - r == 1) || (r == 1 && c == 5) || (r == 5 && c == 1));
    if (maxd >= 6 && (star || ring)) return 16'(WGT_DEFAULT);
    return 16'd0;
  endfunction

  // product divided by 65536, truncated toward zero
  function automatic logic signed [19:0] trunc_q16(input logic signed [35:0] p);
    logic signed [35:0] b;
    b = p + (p[35] ? 36'sd65535 : 36'sd0);
    return b[35:16];
  endfunction

  // floor first, then ceiling (ceiling wins when crossed)
  function automatic logic signed [15:0] clip_lvl(input logic signed [18:0] x,
                                                   input logic signed [15:0] fl,
                                                   input logic signed [15:0] ce);
    logic signed [18:0] y;
    y = x;
    if (y < 19'(fl)) y = 19'(fl);
    if (y > 19'(ce)) y = 19'(ce);
    return y[15:0];
  endfunction

endpackage

// File: rtl/core/pheromone_field_engine_core.sv
`timescale 1ns / 1ps
// pheromone field engine top: config registers, sequencer, shared multiplier, memories
// depends on pfe_pkg and pfe_div
//
// channel   signals                                      dir  handshake
// request   start_i, req_type_i, domain_i, peer_i,       in   start_i & !busy_o
//           value_i
// result    done_o, level_out_o, id_ok_o, evap_loss_o,   out  done_o strobe, one cycle
//           diff_gain_o
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i             in   cfg_we_i
//
// after reset an init pass over all MAX_DOMAINS*MAX_DOMAINS cells loads the weight table
// and levels; busy_o stays high meanwhile. clear weights sweeps the same cells.
// deposit, set and read pass through a level write-back state; a weight write is done in
// idle. a tick runs evaporation over n domains, then, with diffusion on, diffusion for
// each domain, sequenced by the single multiplier and the one-bit-per-cycle divider.
// results cannot be stalled; done_o pulses once per accepted request.

module pheromone_field_engine_core #(
  parameter int MAX_DOMAINS = pfe_pkg::MAX_DOMAINS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         req_type_i,
  input  logic [4:0]         domain_i,
  input  logic [4:0]         peer_i,
  input  logic signed [16:0] value_i,
  output logic               done_o,
  output logic signed [15:0] level_out_o,
  output logic               id_ok_o,
  output logic signed [20:0] evap_loss_o,
  output logic        [19:0] diff_gain_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

  localparam int DW     = $clog2(MAX_DOMAINS);
  localparam int CW     = $clog2(MAX_DOMAINS + 1);
  localparam int WD     = MAX_DOMAINS * MAX_DOMAINS;
  localparam int AW     = $clog2(WD);
  localparam int WS_W   = 16 + DW;
  localparam int WT_W   = 33 + DW;
  localparam int LOSS_W = (18 + DW > 22) ? 18 + DW : 22;
  localparam int GAIN_W = (17 + DW > 21) ? 17 + DW : 21;

  typedef enum logic [14:0] {
    ST_INIT    = 15'b000000000000001,
    ST_IDLE    = 15'b000000000000010,
    ST_LV_WB   = 15'b000000000000100,
    ST_CLR     = 15'b000000000001000,
    ST_EV_RD   = 15'b000000000010000,
    ST_EV_MUL  = 15'b000000000100000,
    ST_EV_WB   = 15'b000000001000000,
    ST_DF_RD   = 15'b000000010000000,
    ST_DF_MUL  = 15'b000000100000000,
    ST_DF_ACC  = 15'b000001000000000,
    ST_DF_DIV  = 15'b000010000000000,
    ST_DF_STEP = 15'b000100000000000,
    ST_DF_WB   = 15'b001000000000000,
    ST_DONE    = 15'b010000000000000,
    ST_SPARE   = 15'b100000000000000
  } state_e;

  // configuration registers
  logic [4:0]         cnt_q;
  logic [15:0]        evap_q, drate_q;
  logic [14:0]        dlim_q;
  logic signed [15:0] floor_q, ceil_q;
  logic               don_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 5'd6;
      evap_q  <= 16'd6554;
      drate_q <= 16'd3277;
      dlim_q  <= 15'd4915;
      floor_q <= 16'sd0;
      ceil_q  <= 16'sd16384;
      don_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfe_pkg::CFG_COUNT: cnt_q   <= cfg_wdata_i[4:0];
        pfe_pkg::CFG_EVAP:  evap_q  <= cfg_wdata_i;
        pfe_pkg::CFG_DIFF:  drate_q <= cfg_wdata_i;
        pfe_pkg::CFG_DLIM:  dlim_q  <= cfg_wdata_i[14:0];
        pfe_pkg::CFG_FLOOR: floor_q <= $signed(cfg_wdata_i);
        pfe_pkg::CFG_CEIL:  ceil_q  <= $signed(cfg_wdata_i);
        pfe_pkg::CFG_DON:   don_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e                    state_q, state_d;
  logic [CW-1:0]             d_q, d_d, j_q, j_d;
  logic [2:0]                req_q, req_d;
  logic signed [16:0]        val_q, val_d;
  logic signed [15:0]        before_q, before_d;
  logic [WS_W-1:0]           wsum_q, wsum_d;
  logic signed [WT_W-1:0]    wt_q, wt_d;
  logic signed [16:0]        mean_q, mean_d;
  logic signed [LOSS_W-1:0]  loss_q, loss_d;
  logic [GAIN_W-1:0]         gain_q, gain_d;
  logic signed [15:0]        res_lvl_q, res_lvl_d;
  logic                      res_ok_q, res_ok_d;

  // memories
  logic signed [15:0] lv_mem [MAX_DOMAINS];
  logic signed [15:0] sn_mem [MAX_DOMAINS];
  logic [15:0]        wt_mem [WD];
  logic               lv_we, sn_we, wt_we;
  logic [DW-1:0]      lv_addr_w, lv_raddr, sn_raddr;
  logic [AW-1:0]      wt_waddr, wt_raddr;
  logic signed [15:0] lv_wdata, sn_wdata;
  logic [15:0]        wt_wdata;
  logic signed [15:0] lv_rdata_q, sn_rdata_q;
  logic [15:0]        wt_rdata_q;

  // shared multiplier
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod_q;

  // divider
  logic                   div_start, div_done;
  logic signed [WT_W-1:0] div_quot;

  pfe_div #(
    .NUM_W (WT_W),
    .DEN_W (WS_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (wt_q),
    .den_i   (wsum_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  logic [CW-1:0]      n_act;
  logic               dom_ok, peer_ok;
  logic [16:0]        keep;
  logic signed [16:0] lim, inc;
  logic signed [15:0] new_lvl;
  logic signed [19:0] tq;
  logic signed [17:0] step;
  logic               last_cell;

  always_comb begin
    n_act   = (32'(cnt_q) > 32'(MAX_DOMAINS)) ? CW'(MAX_DOMAINS) : CW'(cnt_q);
    dom_ok  = 32'(domain_i) < 32'(n_act);
    peer_ok = 32'(peer_i) < 32'(n_act);
    keep    = 17'd65536 - {1'b0, evap_q};
    lim     = $signed({2'b00, dlim_q});
    inc     = (val_q > lim) ? lim : ((val_q < -lim) ? -lim : val_q);
    tq      = pfe_pkg::trunc_q16(prod_q);
    step    = tq[17:0];
    last_cell = (j_q == CW'(MAX_DOMAINS - 1)) && (d_q == CW'(MAX_DOMAINS - 1));
    new_lvl = '0;

    state_d   = state_q;
    d_d       = d_q;
    j_d       = j_q;
    req_d     = req_q;
    val_d     = val_q;
    before_d  = before_q;
    wsum_d    = wsum_q;
    wt_d      = wt_q;
    mean_d    = mean_q;
    loss_d    = loss_q;
    gain_d    = gain_q;
    res_lvl_d = res_lvl_q;
    res_ok_d  = res_ok_q;

    lv_we     = 1'b0;
    sn_we     = 1'b0;
    wt_we     = 1'b0;
    lv_addr_w = d_q[DW-1:0];
    lv_raddr  = d_q[DW-1:0];
    sn_raddr  = j_q[DW-1:0];
    wt_raddr  = AW'(d_q[DW-1:0]) * AW'(MAX_DOMAINS) + AW'(j_q[DW-1:0]);
    wt_waddr  = wt_raddr;
    lv_wdata  = '0;
    sn_wdata  = '0;
    wt_wdata  = '0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;

    case (state_q)
      ST_INIT: begin
        wt_we    = 1'b1;
        wt_wdata = pfe_pkg::wgt_init(int'(d_q), int'(j_q), MAX_DOMAINS);
        lv_we    = (j_q == '0);
        lv_wdata = pfe_pkg::lvl_init(int'(d_q));
        if (last_cell) state_d = ST_IDLE;
        if (j_q == CW'(MAX_DOMAINS - 1)) begin
          j_d = '0;
          d_d = d_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_IDLE: begin
        lv_raddr = DW'(domain_i);
        if (start_i) begin
          req_d     = req_type_i;
          val_d     = value_i;
          d_d       = CW'(domain_i);
          j_d       = '0;
          loss_d    = '0;
          gain_d    = '0;
          res_lvl_d = '0;
          res_ok_d  = 1'b0;
          state_d   = ST_DONE;
          case (req_type_i)
            pfe_pkg::REQ_TICK: begin
              res_ok_d = 1'b1;
              d_d      = '0;
              if (n_act != '0) state_d = ST_EV_RD;
            end
            pfe_pkg::REQ_DEP, pfe_pkg::REQ_SET, pfe_pkg::REQ_READ: begin
              if (dom_ok) begin
                res_ok_d = 1'b1;
                state_d  = ST_LV_WB;
              end
            end
            pfe_pkg::REQ_WGT: begin
              wt_waddr = AW'(DW'(domain_i)) * AW'(MAX_DOMAINS) + AW'(DW'(peer_i));
              wt_wdata = value_i[16] ? 16'd0 : value_i[15:0];
              if (dom_ok && peer_ok) begin
                wt_we    = 1'b1;
                res_ok_d = 1'b1;
              end
            end
            pfe_pkg::REQ_CLEAR: begin
              res_ok_d = 1'b1;
              d_d      = '0;
              state_d  = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_LV_WB: begin
        case (req_q)
          pfe_pkg::REQ_DEP: begin
            new_lvl = pfe_pkg::clip_lvl(19'(lv_rdata_q) + 19'(inc), floor_q, ceil_q);
            lv_we   = 1'b1;
          end
          pfe_pkg::REQ_SET: begin
            new_lvl = pfe_pkg::clip_lvl(19'(val_q), floor_q, ceil_q);
            lv_we   = 1'b1;
          end
          default: new_lvl = lv_rdata_q;
        endcase
        lv_wdata  = new_lvl;
        res_lvl_d = new_lvl;
        state_d   = ST_DONE;
      end
      ST_CLR: begin
        wt_we = 1'b1;
        if (last_cell) state_d = ST_DONE;
        if (j_q == CW'(MAX_DOMAINS - 1)) begin
          j_d = '0;
          d_d = d_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_EV_RD: state_d = ST_EV_MUL;
      ST_EV_MUL: begin
        mul_a    = 18'(lv_rdata_q);
        mul_b    = $signed({1'b0, keep});
        before_d = lv_rdata_q;
        state_d  = ST_EV_WB;
      end
      ST_EV_WB: begin
        new_lvl  = pfe_pkg::clip_lvl(19'(tq), floor_q, ceil_q);
        lv_we    = 1'b1;
        lv_wdata = new_lvl;
        sn_we    = 1'b1;
        sn_wdata = new_lvl;
        loss_d   = loss_q + LOSS_W'(before_q) - LOSS_W'(new_lvl);
        if (d_q + 1'b1 == n_act) begin
          d_d     = '0;
          j_d     = '0;
          wsum_d  = '0;
          wt_d    = '0;
          state_d = don_q ? ST_DF_RD : ST_DONE;
        end else begin
          d_d     = d_q + 1'b1;
          state_d = ST_EV_RD;
        end
      end
      ST_DF_RD: begin
        if (j_q == n_act) begin
          if (wsum_q == '0) begin
            d_d     = d_q + 1'b1;
            j_d     = '0;
            wsum_d  = '0;
            wt_d    = '0;
            if (d_q + 1'b1 == n_act) state_d = ST_DONE;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DF_DIV;
          end
        end else if (j_q == d_q) begin
          j_d = j_q + 1'b1;
        end else begin
          state_d = ST_DF_MUL;
        end
      end
      ST_DF_MUL: begin
        mul_a   = 18'(sn_rdata_q);
        mul_b   = $signed({2'b00, wt_rdata_q});
        wsum_d  = wsum_q + WS_W'(wt_rdata_q);
        state_d = ST_DF_ACC;
      end
      ST_DF_ACC: begin
        wt_d    = wt_q + WT_W'(prod_q);
        j_d     = j_q + 1'b1;
        state_d = ST_DF_RD;
      end
      ST_DF_DIV: begin
        sn_raddr = d_q[DW-1:0];
        if (div_done) begin
          mean_d  = div_quot[16:0];
          state_d = ST_DF_STEP;
        end
      end
      ST_DF_STEP: begin
        sn_raddr = d_q[DW-1:0];
        mul_a    = 18'(mean_q) - 18'(sn_rdata_q);
        mul_b    = $signed({2'b00, drate_q});
        state_d  = ST_DF_WB;
      end
      ST_DF_WB: begin
        new_lvl  = pfe_pkg::clip_lvl(19'(sn_rdata_q) + 19'(step), floor_q, ceil_q);
        lv_we    = 1'b1;
        lv_wdata = new_lvl;
        gain_d   = gain_q + GAIN_W'(step[17] ? -step : step);
        d_d      = d_q + 1'b1;
        j_d      = '0;
        wsum_d   = '0;
        wt_d     = '0;
        state_d  = (d_q + 1'b1 == n_act) ? ST_DONE : ST_DF_RD;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      d_q         <= '0;
      j_q         <= '0;
      req_q       <= '0;
      done_o      <= 1'b0;
      level_out_o <= '0;
      id_ok_o     <= 1'b0;
      evap_loss_o <= '0;
      diff_gain_o <= '0;
    end else begin
      state_q <= state_d;
      d_q     <= d_d;
      j_q     <= j_d;
      req_q   <= req_d;
      done_o  <= (state_q == ST_DONE);
      if (state_q == ST_DONE) begin
        level_out_o <= res_lvl_q;
        id_ok_o     <= res_ok_q;
        if (loss_q > LOSS_W'(pfe_pkg::LOSS_MAX)) evap_loss_o <= 21'(pfe_pkg::LOSS_MAX);
        else if (loss_q < LOSS_W'(pfe_pkg::LOSS_MIN)) evap_loss_o <= 21'(pfe_pkg::LOSS_MIN);
        else evap_loss_o <= loss_q[20:0];
        if (gain_q > GAIN_W'(pfe_pkg::GAIN_MAX)) diff_gain_o <= 20'(pfe_pkg::GAIN_MAX);
        else diff_gain_o <= gain_q[19:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    before_q  <= before_d;
    wsum_q    <= wsum_d;
    wt_q      <= wt_d;
    mean_q    <= mean_d;
    loss_q    <= loss_d;
    gain_q    <= gain_d;
    res_lvl_q <= res_lvl_d;
    res_ok_q  <= res_ok_d;
    prod_q    <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (lv_we) lv_mem[lv_addr_w] <= lv_wdata;
    lv_rdata_q <= lv_mem[lv_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sn_we) sn_mem[d_q[DW-1:0]] <= sn_wdata;
    sn_rdata_q <= sn_mem[sn_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) wt_mem[wt_waddr] <= wt_wdata;
    wt_rdata_q <= wt_mem[wt_raddr];
  end

  assign busy_o = (state_q != ST_IDLE);

  // every accepted beat moves the sequencer out of idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted beat did not start work");

  // a result strobe is never held high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DF_DIV)
    else $error("divider result outside division wait");

  // rejected ids report nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !id_ok_o |-> level_out_o == '0 && evap_loss_o == '0 && diff_gain_o == '0)
    else $error("rejected request carries data");

endmodule

// File: rtl/core/pfe_div.sv
`timescale 1ns / 1ps
// serial signed-by-unsigned divider, one quotient bit per cycle, truncating
// no package dependencies

module pfe_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic        [DEN_W-1:0] den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = num_i[NUM_W-1];
      rem_d  = '0;
      quo_d  = num_i[NUM_W-1] ? (~num_i + 1'b1) : num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for pheromone_field_engine_core: directed and random requests
// checked against a cycle-free field predictor; depends on pfe_pkg and the core rtl

module tb_top;

  localparam int ND        = 16;
  localparam int WDOG_MAX  = 200000;
  localparam int N_RANDOM  = 1500;

  typedef struct packed {
    logic [2:0]         kind;
    logic [4:0]         dom;
    logic [4:0]         peer;
    logic signed [16:0] val;
  } req_t;

  typedef struct packed {
    logic signed [15:0] level;
    logic               ok;
    logic signed [20:0] loss;
    logic        [19:0] gain;
  } res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         req_type_i = '0;
  logic [4:0]         domain_i = '0;
  logic [4:0]         peer_i = '0;
  logic signed [16:0] value_i = '0;
  logic               done_o;
  logic signed [15:0] level_out_o;
  logic               id_ok_o;
  logic signed [20:0] evap_loss_o;
  logic        [19:0] diff_gain_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_wdata_i = '0;

  pheromone_field_engine_core dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  int unsigned m_count, m_evap, m_diff, m_dlim, m_don;
  int          m_floor, m_ceil;
  int          m_lvl [ND];
  int unsigned m_wgt [ND][ND];

  req_t pending_reqs[$];
  res_t expected_res[$];
  int   errors = 0;
  int   n_done = 0;
  int   n_ticks = 0;
  int   idle_pct = 0;
  int   wdog = 0;

  function automatic int clip(longint x);
    if (x < m_floor) x = m_floor;
    if (x > m_ceil) x = m_ceil;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return int'(x);
  endfunction

  function automatic void field_reset();
    m_count = 6; m_evap = 6554; m_diff = 3277; m_dlim = 4915;
    m_floor = 0; m_ceil = 16384; m_don = 1;
    for (int d = 0; d < ND; d++) begin
      m_lvl[d] = pfe_pkg::LVL_INIT[d];
      for (int c = 0; c < ND; c++) m_wgt[d][c] = 0;
    end
    for (int d = 1; d < 6; d++) begin
      m_wgt[0][d] = pfe_pkg::WGT_DEFAULT; m_wgt[d][0] = pfe_pkg::WGT_DEFAULT;
      m_wgt[d][d == 5 ? 1 : d + 1] = pfe_pkg::WGT_DEFAULT;
      m_wgt[d == 5 ? 1 : d + 1][d] = pfe_pkg::WGT_DEFAULT;
    end
  endfunction

  function automatic res_t field_step(req_t r);
    res_t        o;
    int unsigned n;
    longint      loss, gain, keep, prev_lvl, wsum, wt, mean, step, v, lim;
    int          snap [ND];
    n = (m_count > ND) ? ND : m_count;
    o = '0;
    v = r.val;
    case (r.kind)
      pfe_pkg::REQ_TICK: begin
        loss = 0; gain = 0; keep = 65536 - longint'(m_evap);
        for (int d = 0; d < n; d++) begin
          prev_lvl = m_lvl[d];
          m_lvl[d] = clip((prev_lvl * keep) / 65536);
          loss += prev_lvl - m_lvl[d];
          snap[d] = m_lvl[d];
        end
        if (m_don != 0)
          for (int d = 0; d < n; d++) begin
            wsum = 0; wt = 0;
            for (int j = 0; j < n; j++)
              if (j != d) begin
                wsum += m_wgt[d][j];
                wt += longint'(m_wgt[d][j]) * snap[j];
              end
            if (wsum != 0) begin
              mean = wt / wsum;
              step = (longint'(m_diff) * (mean - snap[d])) / 65536;
              m_lvl[d] = clip(snap[d] + step);
              gain += step < 0 ? -step : step;
            end
          end
        if (loss > pfe_pkg::LOSS_MAX) loss = pfe_pkg::LOSS_MAX;
        if (loss < pfe_pkg::LOSS_MIN) loss = pfe_pkg::LOSS_MIN;
        if (gain > pfe_pkg::GAIN_MAX) gain = pfe_pkg::GAIN_MAX;
        o.loss = 21'(loss); o.gain = 20'(gain); o.ok = 1'b1;
      end
      pfe_pkg::REQ_DEP: if (r.dom < n) begin
        lim = m_dlim;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        m_lvl[r.dom] = clip(m_lvl[r.dom] + v);
        o.level = 16'(m_lvl[r.dom]); o.ok = 1'b1;
      end
      pfe_pkg::REQ_SET: if (r.dom < n) begin
        m_lvl[r.dom] = clip(v);
        o.level = 16'(m_lvl[r.dom]); o.ok = 1'b1;
      end
      pfe_pkg::REQ_READ: if (r.dom < n) begin
        o.level = 16'(m_lvl[r.dom]); o.ok = 1'b1;
      end
      pfe_pkg::REQ_WGT: if (r.dom < n && r.peer < n) begin
        m_wgt[r.dom][r.peer] = v < 0 ? 0 : int'(v) & 16'hFFFF;
        o.ok = 1'b1;
      end
      pfe_pkg::REQ_CLEAR: begin
        for (int d = 0; d < ND; d++)
          for (int c = 0; c < ND; c++) m_wgt[d][c] = 0;
        o.ok = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic void queue_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // driver
  always @(posedge clk_i) begin
    req_t r;
    res_t e;
    if (rst_ni && start_i && !busy_o) begin
      r = {req_type_i, domain_i, peer_i, value_i};
      e = field_step(r);
      expected_res.insert(expected_res.size(), e);
      if (r.kind == pfe_pkg::REQ_TICK) n_ticks++;
    end
    if (rst_ni && !(start_i && busy_o) && pending_reqs.size() > 0 &&
        $urandom_range(99) >= idle_pct) begin
      r = pending_reqs[0];
      pending_reqs.delete(0);
      start_i <= 1'b1;
      {req_type_i, domain_i, peer_i, value_i} <= r;
    end else if (!(start_i && busy_o)) begin
      start_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni && done_o) begin
      n_done++;
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        w = expected_res[0];
        expected_res.delete(0);
        if (level_out_o !== w.level) report_mismatch("level_out", level_out_o, w.level);
        if (id_ok_o !== w.ok) report_mismatch("id_ok", id_ok_o, w.ok);
        if (evap_loss_o !== w.loss) report_mismatch("evap_loss", evap_loss_o, w.loss);
        if (diff_gain_o !== w.gain) report_mismatch("diff_gain", diff_gain_o, w.gain);
      end
    end
  end

  // watchdog on cycles without any accepted beat or result strobe
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("watchdog expired, nothing accepted for %0d cycles", wdog);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic cfg_write(pfe_pkg::cfg_idx_e idx, int data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= 16'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pfe_pkg::CFG_COUNT: m_count = data & 5'h1F;
      pfe_pkg::CFG_EVAP:  m_evap = data & 16'hFFFF;
      pfe_pkg::CFG_DIFF:  m_diff = data & 16'hFFFF;
      pfe_pkg::CFG_DLIM:  m_dlim = data & 15'h7FFF;
      pfe_pkg::CFG_FLOOR: m_floor = int'($signed(16'(data)));
      pfe_pkg::CFG_CEIL:  m_ceil = int'($signed(16'(data)));
      pfe_pkg::CFG_DON:   m_don = data & 1;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || start_i || expected_res.size() > 0 || busy_o)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic req_t mk(pfe_pkg::req_e k, int d, int p, int v);
    req_t r;
    r.kind = k; r.dom = 5'(d); r.peer = 5'(p); r.val = 17'(v);
    return r;
  endfunction

  // mostly valid ids; deposits, sets, reads and weight writes between occasional ticks, clears and random kinds
  function automatic req_t rand_req();
    req_t        r;
    int unsigned sel;
    int unsigned n;
    n = (m_count == 0) ? 1 : ((m_count > ND) ? ND : m_count);
    sel = $urandom_range(99);
    r.kind = sel < 12 ? pfe_pkg::REQ_TICK : sel < 35 ? pfe_pkg::REQ_DEP :
             sel < 50 ? pfe_pkg::REQ_SET : sel < 70 ? pfe_pkg::REQ_READ :
             sel < 93 ? pfe_pkg::REQ_WGT : sel < 95 ? pfe_pkg::REQ_CLEAR :
             3'($urandom_range(7));
    r.dom  = $urandom_range(9) == 0 ? 5'($urandom) : 5'($urandom_range(n - 1));
    r.peer = $urandom_range(9) == 0 ? 5'($urandom) : 5'($urandom_range(n - 1));
    r.val  = $urandom_range(3) == 0 ? 17'($urandom) : 17'($urandom_range(65535));
    if (r.kind != pfe_pkg::REQ_WGT && $urandom_range(1)) r.val = 17'($signed(16'($urandom)));
    return r;
  endfunction

  initial begin
    field_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // directed: every request kind, field extremes, invalid ids, unknown kinds
    queue_req(mk(pfe_pkg::REQ_READ, 0, 0, 0));
    queue_req(mk(pfe_pkg::REQ_TICK, 0, 0, 0));
    queue_req(mk(pfe_pkg::REQ_DEP, 1, 0, 65535));
    queue_req(mk(pfe_pkg::REQ_DEP, 2, 0, -65536));
    queue_req(mk(pfe_pkg::REQ_SET, 3, 0, -65536));
    queue_req(mk(pfe_pkg::REQ_SET, 4, 0, 65535));
    queue_req(mk(pfe_pkg::REQ_READ, 31, 0, 0));
    queue_req(mk(pfe_pkg::REQ_DEP, 6, 0, 100));
    queue_req(mk(pfe_pkg::REQ_WGT, 0, 31, 1000));
    queue_req(mk(pfe_pkg::REQ_WGT, 2, 2, 65535));
    queue_req(mk(pfe_pkg::REQ_WGT, 1, 3, -5));
    queue_req(mk(pfe_pkg::REQ_WGT, 3, 1, 65535));
    queue_req(mk(pfe_pkg::REQ_TICK, 0, 0, 0));
    queue_req(mk(pfe_pkg::REQ_TICK, 0, 0, 0));
    queue_req(req_t'({3'd6, 5'd1, 5'd1, 17'h1FFFF}));
    queue_req(req_t'({3'd7, 5'd31, 5'd31, 17'h0AAAA}));
    queue_req(mk(pfe_pkg::REQ_CLEAR, 0, 0, 0));
    queue_req(mk(pfe_pkg::REQ_TICK, 0, 0, 0));
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          cfg_write(pfe_pkg::CFG_COUNT, 16); cfg_write(pfe_pkg::CFG_EVAP, 0);
          cfg_write(pfe_pkg::CFG_DIFF, 65535);
          cfg_write(pfe_pkg::CFG_DLIM, 32767); cfg_write(pfe_pkg::CFG_FLOOR, -32768);
          cfg_write(pfe_pkg::CFG_CEIL, 32767); cfg_write(pfe_pkg::CFG_DON, 1);
        end
        1: begin
          cfg_write(pfe_pkg::CFG_COUNT, 31); cfg_write(pfe_pkg::CFG_EVAP, 65535);
          cfg_write(pfe_pkg::CFG_DIFF, 0);
          cfg_write(pfe_pkg::CFG_DLIM, 0); cfg_write(pfe_pkg::CFG_DON, 0);
        end
        2: begin
          cfg_write(pfe_pkg::CFG_COUNT, 0); cfg_write(pfe_pkg::CFG_DLIM, 4915);
        end
        3: begin
          // crossed bounds: ceiling wins
          cfg_write(pfe_pkg::CFG_COUNT, 1); cfg_write(pfe_pkg::CFG_FLOOR, 8000);
          cfg_write(pfe_pkg::CFG_CEIL, -100);
          cfg_write(pfe_pkg::CFG_EVAP, 30000);
        end
        default: begin
          cfg_write(pfe_pkg::CFG_COUNT, $urandom_range(2, 16));
          cfg_write(pfe_pkg::CFG_EVAP, $urandom_range(65535));
          cfg_write(pfe_pkg::CFG_DIFF, $urandom_range(65535));
          cfg_write(pfe_pkg::CFG_DLIM, $urandom_range(32767));
          cfg_write(pfe_pkg::CFG_FLOOR, -$urandom_range(32768));
          cfg_write(pfe_pkg::CFG_CEIL, $urandom_range(32767));
          cfg_write(pfe_pkg::CFG_DON, $urandom_range(1));
        end
      endcase
      idle_pct = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 47 : (ph % 4 == 2) ? 12 : 47;
      for (int i = 0; i < N_RANDOM / 8; i++) queue_req(rand_req());
      drain();
    end

    $display("covered %0d results including %0d ticks over 8 register settings",
             n_done, n_ticks);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
